FILE: hdl/lrupr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths, reset values and the structs that travel along the frame
// cell chain.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned OIDX_W  = 4;

  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Search token handed from one cell to the next.
  typedef struct packed {
    logic               live;
    logic [PAGE_W-1:0]  page;
    logic               found;
    logic               best_valid;
    logic [PAGE_W-1:0]  best_page;
    logic [STAMP_W-1:0] best_stamp;
  } tok_t;

  // Update broadcast to the cells when a request completes.
  typedef struct packed {
    logic               en;
    logic               fill;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } frame_wr_t;

endpackage

`default_nettype wire

FILE: hdl/lru_page_replacement_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU page replacement core
// Keeps a row of frame cells and serves page requests with least recently
// used replacement, reporting hit or fault, the frame used and any eviction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                     Payload
//  request   in         page_valid_i / page_ready_o   page_number_i
//  result    out        result_valid_o / result_ready_i
//                                  hit, frame_index, evicted_valid/page, totals
//  config    in         cfg_we_i (no wait)            cfg_wdata_i (frames in use)
//
// A request walks the cell chain one frame per cycle while the result side does not stall,
// and the next request can be taken only once it has left the last cell.
// The result is registered; a new request is accepted while it waits.
// A stalled result holds the finished search token in the last cell.
// Reset clears all frames, the request clock and both totals.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [lrupr_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire                           page_valid_i,
  output logic                          page_ready_o,
  input  wire  [lrupr_pkg::PAGE_W-1:0]  page_number_i,
  output logic                          result_valid_o,
  input  wire                           result_ready_i,
  output logic                          hit_o,
  output logic [lrupr_pkg::OIDX_W-1:0]  frame_index_o,
  output logic                          evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]  evicted_page_o,
  output logic [lrupr_pkg::TOTAL_W-1:0] hit_total_o,
  output logic [lrupr_pkg::TOTAL_W-1:0] fault_total_o
);
  import lrupr_pkg::*;

  localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CMP_W-1:0] MAX_N = CMP_W'(MAX_FRAMES);
  localparam logic [CMP_W-1:0] ONE_N = CMP_W'(1);

  logic [CFG_W-1:0]   frames_in_use_q;
  logic [CMP_W-1:0]   cfg_ext;
  logic [CMP_W-1:0]   active_n;
  logic               busy_q;
  logic [STAMP_W-1:0] clock_q;
  logic [TOTAL_W-1:0] hits_q, faults_q;
  logic               accept;
  logic               stall;
  logic               commit;
  logic               found;
  logic [IDX_W-1:0]   sel_idx;

  tok_t             tok_chain   [0:MAX_FRAMES];
  logic [IDX_W-1:0] match_chain [0:MAX_FRAMES];
  logic [IDX_W-1:0] best_chain  [0:MAX_FRAMES];
  logic [MAX_FRAMES-1:0] cell_use;
  logic [MAX_FRAMES-1:0] live_vec;
  frame_wr_t        frame_wr;

  // Frame count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      frames_in_use_q <= cfg_wdata_i;
    end
  end

  // Clamp the configured count to 1..MAX_FRAMES.
  always_comb begin
    cfg_ext = CMP_W'(frames_in_use_q);
    if (cfg_ext == '0) begin
      active_n = ONE_N;
    end else if (cfg_ext > MAX_N) begin
      active_n = MAX_N;
    end else begin
      active_n = cfg_ext;
    end
  end

  // Handshake and chain control.
  assign page_ready_o = !busy_q;
  assign accept       = page_valid_i && page_ready_o;
  assign stall        = tok_chain[MAX_FRAMES].live && result_valid_o && !result_ready_i;
  assign commit       = tok_chain[MAX_FRAMES].live && !stall;

  // Launch token for a new request.
  always_comb begin
    tok_chain[0]      = '0;
    tok_chain[0].live = accept;
    tok_chain[0].page = page_number_i;
    match_chain[0]    = '0;
    best_chain[0]     = '0;
  end

  // Row of frame cells.
  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    assign cell_use[k] = (CMP_W'(k) < active_n);
    assign live_vec[k] = tok_chain[k+1].live;

    lrupr_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .advance_i   (!stall),
      .use_i       (cell_use[k]),
      .tok_i       (tok_chain[k]),
      .match_idx_i (match_chain[k]),
      .best_idx_i  (best_chain[k]),
      .tok_o       (tok_chain[k+1]),
      .match_idx_o (match_chain[k+1]),
      .best_idx_o  (best_chain[k+1]),
      .wr_i        (frame_wr),
      .wr_idx_i    (sel_idx)
    );
  end

  // Frame update when the token leaves the last cell.
  always_comb begin
    found          = tok_chain[MAX_FRAMES].found;
    sel_idx        = found ? match_chain[MAX_FRAMES] : best_chain[MAX_FRAMES];
    frame_wr.en    = commit;
    frame_wr.fill  = !found;
    frame_wr.page  = tok_chain[MAX_FRAMES].page;
    frame_wr.stamp = clock_q;
  end

  // Busy flag and saturating request clock.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      clock_q <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        if (clock_q != STAMP_MAX) begin
          clock_q <= clock_q + STAMP_W'(1);
        end
      end else if (commit) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Saturating totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      faults_q <= '0;
    end else if (commit) begin
      if (found) begin
        if (hits_q != TOTAL_MAX) begin
          hits_q <= hits_q + TOTAL_W'(1);
        end
      end else if (faults_q != TOTAL_MAX) begin
        faults_q <= faults_q + TOTAL_W'(1);
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else if (commit) begin
      result_valid_o <= 1'b1;
    end else if (result_ready_i) begin
      result_valid_o <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_o           <= found;
      frame_index_o   <= OIDX_W'(sel_idx);
      evicted_valid_o <= !found && tok_chain[MAX_FRAMES].best_valid;
      evicted_page_o  <= (!found && tok_chain[MAX_FRAMES].best_valid) ?
                         tok_chain[MAX_FRAMES].best_page : '0;
      if (found) begin
        hit_total_o   <= (hits_q != TOTAL_MAX) ? hits_q + TOTAL_W'(1) : hits_q;
        fault_total_o <= faults_q;
      end else begin
        hit_total_o   <= hits_q;
        fault_total_o <= (faults_q != TOTAL_MAX) ? faults_q + TOTAL_W'(1) : faults_q;
      end
    end
  end

  // At most one request is ever walking the chain.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(live_vec))
    else $error("more than one live token in the cell chain");

  // A token in the chain always belongs to an accepted, unfinished request.
  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_vec != '0) |-> busy_q)
    else $error("live token while the core is not busy");

  // Completion releases the request side on the next cycle.
  a_commit_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> page_ready_o)
    else $error("core still busy after a request completed");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

  // Without an eviction the evicted page reads as zero.
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !evicted_valid_o) |-> (evicted_page_o == '0))
    else $error("evicted page not zero without an eviction");

endmodule

`default_nettype wire

FILE: hdl/lrupr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame (valid, page, stamp), checks the passing search token for
// a match and for a smaller stamp, and registers the token for its neighbor.
// ----------------------------------------------------------------------------
module lrupr_cell #(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    advance_i,
  input  wire                    use_i,
  input  wire lrupr_pkg::tok_t   tok_i,
  input  wire  [IDX_W-1:0]       match_idx_i,
  input  wire  [IDX_W-1:0]       best_idx_i,
  output lrupr_pkg::tok_t        tok_o,
  output logic [IDX_W-1:0]       match_idx_o,
  output logic [IDX_W-1:0]       best_idx_o,
  input  wire lrupr_pkg::frame_wr_t wr_i,
  input  wire  [IDX_W-1:0]       wr_idx_i
);
  import lrupr_pkg::*;

  localparam logic [IDX_W-1:0] SELF = IDX_W'(CELL_IDX);

  logic               valid_q;
  logic [PAGE_W-1:0]  page_q;
  logic [STAMP_W-1:0] stamp_q;

  tok_t             tok_d, tok_q;
  logic [IDX_W-1:0] match_d, match_q;
  logic [IDX_W-1:0] best_d, best_q;

  // Match and minimum-stamp step for this frame.
  always_comb begin
    tok_d   = tok_i;
    match_d = match_idx_i;
    best_d  = best_idx_i;
    if (use_i && tok_i.live) begin
      if (!tok_i.found && valid_q && (page_q == tok_i.page)) begin
        tok_d.found = 1'b1;
        match_d     = SELF;
      end
      if ((CELL_IDX == 0) || (stamp_q < tok_i.best_stamp)) begin
        tok_d.best_valid = valid_q;
        tok_d.best_page  = page_q;
        tok_d.best_stamp = stamp_q;
        best_d           = SELF;
      end
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      match_q <= '0;
      best_q  <= '0;
    end else if (advance_i) begin
      tok_q   <= tok_d;
      match_q <= match_d;
      best_q  <= best_d;
    end
  end

  // Frame contents, updated when a request completes on this frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      page_q  <= '0;
      stamp_q <= '0;
    end else if (wr_i.en && (wr_idx_i == SELF)) begin
      stamp_q <= wr_i.stamp;
      if (wr_i.fill) begin
        valid_q <= 1'b1;
        page_q  <= wr_i.page;
      end
    end
  end

  assign tok_o       = tok_q;
  assign match_idx_o = match_q;
  assign best_idx_o  = best_q;

endmodule

`default_nettype wire

FILE: tb/tb_lru_page_replacement_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement core testbench
// Drives page requests with random gaps and result stalls, tracks the frame
// table in a scoreboard class, and compares every result field by field
// across several frame-count settings.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_core;

  localparam int unsigned MAX_FRAMES = 16;
  localparam int unsigned MAX_WAIT   = 13;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned HOLD_AT    = 400;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned POOL_SIZE  = 24;

  // One result of the block.
  typedef struct packed {
    logic                          hit;
    logic [lrupr_pkg::OIDX_W-1:0]  frame_index;
    logic                          evicted_valid;
    logic [lrupr_pkg::PAGE_W-1:0]  evicted_page;
    logic [lrupr_pkg::TOTAL_W-1:0] hit_total;
    logic [lrupr_pkg::TOTAL_W-1:0] fault_total;
  } page_outcome_t;

  // Frame table tracker: predicts the outcome of each accepted request and
  // checks the results that come back in order.
  class lru_frame_tracker;
    logic [lrupr_pkg::CFG_W-1:0]   frames_cfg;
    bit                            slot_used [MAX_FRAMES];
    logic [lrupr_pkg::PAGE_W-1:0]  slot_page [MAX_FRAMES];
    logic [lrupr_pkg::STAMP_W-1:0] slot_age  [MAX_FRAMES];
    logic [lrupr_pkg::STAMP_W-1:0] use_tick;
    logic [lrupr_pkg::TOTAL_W-1:0] hit_count;
    logic [lrupr_pkg::TOTAL_W-1:0] fault_count;
    page_outcome_t                 pending_outcomes[$];
    int                            mismatches;

    function new();
      frames_cfg  = lrupr_pkg::CFG_RESET;
      use_tick    = '0;
      hit_count   = '0;
      fault_count = '0;
      mismatches  = 0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        slot_used[j] = 1'b0;
        slot_page[j] = '0;
        slot_age[j]  = '0;
      end
    endfunction

    function void set_frames(logic [lrupr_pkg::CFG_W-1:0] value);
      frames_cfg = value;
    endfunction

    function int unsigned active_frames();
      if (frames_cfg == 0) return 1;
      if (frames_cfg > MAX_FRAMES) return MAX_FRAMES;
      return 32'(frames_cfg);
    endfunction

    // An accepted request: search, replace and queue the expected outcome.
    function void note_page(logic [lrupr_pkg::PAGE_W-1:0] page);
      page_outcome_t                 o;
      int unsigned                   n;
      int unsigned                   slot;
      bit                            found;
      logic [lrupr_pkg::STAMP_W-1:0] best;
      n     = active_frames();
      slot  = 0;
      found = 1'b0;
      o     = '0;
      if (use_tick != lrupr_pkg::STAMP_MAX) use_tick++;
      for (int j = 0; j < n; j++) begin
        if (!found && slot_used[j] && slot_page[j] == page) begin
          found = 1'b1;
          slot  = j;
        end
      end
      if (found) begin
        slot_age[slot] = use_tick;
        if (hit_count != lrupr_pkg::TOTAL_MAX) hit_count++;
      end else begin
        // The first frame with the smallest stamp loses its page.
        best = slot_age[0];
        for (int j = 1; j < n; j++) begin
          if (slot_age[j] < best) begin
            best = slot_age[j];
            slot = j;
          end
        end
        if (slot_used[slot]) begin
          o.evicted_valid = 1'b1;
          o.evicted_page  = slot_page[slot];
        end
        slot_used[slot] = 1'b1;
        slot_page[slot] = page;
        slot_age[slot]  = use_tick;
        if (fault_count != lrupr_pkg::TOTAL_MAX) fault_count++;
      end
      o.hit         = found;
      o.frame_index = slot[lrupr_pkg::OIDX_W-1:0];
      o.hit_total   = hit_count;
      o.fault_total = fault_count;
      pending_outcomes.push_back(o);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // A result left the block: compare it with the oldest expectation.
    function void check_outcome(page_outcome_t seen);
      page_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending, expected none, actual %0h",
                 $time, seen);
        return;
      end
      want = pending_outcomes.pop_front();
      compare_field("hit", 32'(want.hit), 32'(seen.hit));
      compare_field("frame_index", 32'(want.frame_index), 32'(seen.frame_index));
      compare_field("evicted_valid", 32'(want.evicted_valid), 32'(seen.evicted_valid));
      compare_field("evicted_page", 32'(want.evicted_page), 32'(seen.evicted_page));
      compare_field("hit_total", want.hit_total, seen.hit_total);
      compare_field("fault_total", want.fault_total, seen.fault_total);
    endfunction
  endclass

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          cfg_we_i       = 1'b0;
  logic [lrupr_pkg::CFG_W-1:0]   cfg_wdata_i    = '0;
  logic                          page_valid_i   = 1'b0;
  logic                          page_ready_o;
  logic [lrupr_pkg::PAGE_W-1:0]  page_number_i  = '0;
  logic                          result_valid_o;
  logic                          result_ready_i = 1'b0;
  logic                          hit_o;
  logic [lrupr_pkg::OIDX_W-1:0]  frame_index_o;
  logic                          evicted_valid_o;
  logic [lrupr_pkg::PAGE_W-1:0]  evicted_page_o;
  logic [lrupr_pkg::TOTAL_W-1:0] hit_total_o;
  logic [lrupr_pkg::TOTAL_W-1:0] fault_total_o;

  lru_frame_tracker             tracker = new();
  bit                           no_idle = 1'b0;
  int unsigned                  results_taken = 0;
  int unsigned                  idle_cycles = 0;
  logic [lrupr_pkg::PAGE_W-1:0] page_pool [POOL_SIZE];

  lru_page_replacement_core #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .page_valid_i   (page_valid_i),
    .page_ready_o   (page_ready_o),
    .page_number_i  (page_number_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .hit_total_o    (hit_total_o),
    .fault_total_o  (fault_total_o)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Offer one request after a random gap and hold it until it is accepted.
  task automatic send_page(input logic [lrupr_pkg::PAGE_W-1:0] page);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      page_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    page_valid_i  <= 1'b1;
    page_number_i <= page;
    do @(posedge clk_i); while (!page_ready_o);
    tracker.note_page(page);
  endtask

  // Write the frame count while the block is idle.
  task automatic write_frames(input logic [lrupr_pkg::CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_frames(value);
  endtask

  // Stop offering, wait for every result, then let the search chain settle.
  task automatic drain_requests();
    page_valid_i <= 1'b0;
    while (tracker.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_FRAMES + 8) @(posedge clk_i);
  endtask

  // Mostly pages from a shared working set so that hits and evictions mix;
  // the rest are arbitrary pages.
  task automatic run_random(input logic [lrupr_pkg::CFG_W-1:0] frames,
                            input int unsigned count, input bit quiet);
    int unsigned span;
    int unsigned active;
    logic [lrupr_pkg::PAGE_W-1:0] page;
    write_frames(frames);
    no_idle = quiet;
    active  = tracker.active_frames();
    span    = active + $urandom_range(0, 4);
    if (span > POOL_SIZE) span = POOL_SIZE;
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 85) page = page_pool[$urandom_range(0, span - 1)];
      else page = 16'($urandom_range(0, 16'hFFFF));
      send_page(page);
    end
    drain_requests();
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, one long hold-off to back up the block.
  initial begin
    page_outcome_t seen;
    int unsigned   stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (results_taken == HOLD_AT) stall = LONG_HOLD;
      if (stall > 0) begin
        result_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ready_i <= 1'b1;
      do @(posedge clk_i); while (!result_valid_o);
      seen.hit           = hit_o;
      seen.frame_index   = frame_index_o;
      seen.evicted_valid = evicted_valid_o;
      seen.evicted_page  = evicted_page_o;
      seen.hit_total     = hit_total_o;
      seen.fault_total   = fault_total_o;
      tracker.check_outcome(seen);
      results_taken++;
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if ((page_valid_i && page_ready_o) || (result_valid_o && result_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed requests, then random phases.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme pages, hits on them, then a full table and an eviction.
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    for (int p = 1; p <= 14; p++) send_page(p[lrupr_pkg::PAGE_W-1:0]);
    send_page(16'h8000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    drain_requests();

    for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = 16'($urandom_range(0, 16'hFFFF));

    // Frame counts include zero, one, the maximum and values above it;
    // lowering and raising the count brings parked frames back.
    run_random(5'd1, 150, 1'b0);
    run_random(5'd0, 100, 1'b1);
    run_random(5'd31, 200, 1'b0);
    run_random(5'd4, 250, 1'b0);
    run_random(5'd16, 250, 1'b0);
    run_random(5'd17, 150, 1'b1);
    run_random(5'd2, 150, 1'b0);
    run_random(5'd8, 250, 1'b0);
    run_random(5'd10, 150, 1'b0);
    run_random(5'd16, 150, 1'b0);

    if (tracker.mismatches == 0 && tracker.pending_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
